// ===== design/gcl_pkg.sv =====
// shared constants, config register codes and helpers for the golomb code length block
// no dependencies; used by gcl_cell, gcl_tail and golomb_code_length
package gcl_pkg;

  localparam int VALUE_WIDTH_DEF = 16;

  localparam int DIV_W      = 16;
  localparam int ORDER_W    = 4;
  localparam int LEN_W      = 17;
  localparam int EXTRA_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BITLEN_W   = 7;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_MODE       = 2'd0,
    CFG_GOLOMB_DIVISOR  = 2'd1,
    CFG_EXPGOLOMB_ORDER = 2'd2
  } cfg_index_t;

  typedef enum logic {
    MODE_GOLOMB    = 1'b0,
    MODE_EXPGOLOMB = 1'b1
  } code_mode_t;

  // position of the highest set bit plus one, zero for zero
  function automatic logic [BITLEN_W-1:0] bit_length(input logic [63:0] x);
    logic [BITLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        n = BITLEN_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ===== design/gcl_cell.sv =====
// one restoring division step of the quotient chain, registered with its own valid
// depends on gcl_pkg
module gcl_cell #(
  parameter int VW = gcl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  output logic                     down_valid,
  input  logic                     down_ready,
  input  logic [gcl_pkg::DIV_W-1:0] divisor,
  input  logic [gcl_pkg::DIV_W-1:0] in_rem,
  input  logic [VW-1:0]            in_dq,
  input  logic [VW:0]              in_top,
  output logic [gcl_pkg::DIV_W-1:0] out_rem,
  output logic [VW-1:0]            out_dq,
  output logic [VW:0]              out_top
);

  logic                      valid_r;
  logic [gcl_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [VW-1:0]             dq_r, dq_nxt;
  logic [VW:0]               top_r;
  logic [gcl_pkg::DIV_W:0]   trial;
  logic [gcl_pkg::DIV_W:0]   diff;
  logic                      qbit;

  // dividend bits leave at the top of dq while quotient bits enter at the bottom
  always_comb begin
    trial   = {in_rem, in_dq[VW-1]};
    diff    = trial - {1'b0, divisor};
    qbit    = (trial >= {1'b0, divisor});
    rem_nxt = qbit ? diff[gcl_pkg::DIV_W-1:0] : trial[gcl_pkg::DIV_W-1:0];
    dq_nxt  = {in_dq[VW-2:0], qbit};
  end

  assign up_ready   = !valid_r || down_ready;
  assign down_valid = valid_r;
  assign out_rem    = rem_r;
  assign out_dq     = dq_r;
  assign out_top    = top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_valid && up_ready) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
      top_r <= in_top;
    end
  end

endmodule

// ===== design/gcl_tail.sv =====
// final length assembly for both code families, saturation and the output register
// depends on gcl_pkg
module gcl_tail #(
  parameter int VW = gcl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [VW-1:0]               quo,
  input  logic [gcl_pkg::DIV_W-1:0]   rem,
  input  logic [VW:0]                 top,
  input  logic                        mode,
  input  logic [gcl_pkg::ORDER_W-1:0] order,
  input  logic [gcl_pkg::LEN_W-1:0]   thresh,
  input  logic [gcl_pkg::EXTRA_W-1:0] extra_lo,
  input  logic [gcl_pkg::EXTRA_W-1:0] extra_hi,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gcl_pkg::LEN_W-1:0]   out_code_length
);

  localparam int SUM_W = (VW + 2 > 18) ? VW + 2 : 18;

  logic                             valid_r;
  logic [gcl_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic [gcl_pkg::EXTRA_W-1:0]      extra;
  logic [gcl_pkg::BITLEN_W-1:0]     top_bits;
  logic [SUM_W-1:0]                 sum_g;
  logic [SUM_W-1:0]                 sum_e;
  logic [SUM_W-1:0]                 sum;

  always_comb begin
    // truncated binary: short remainder code below the threshold
    extra    = ({1'b0, rem} < thresh) ? extra_lo : extra_hi;
    sum_g    = SUM_W'(quo) + SUM_W'(1) + SUM_W'(extra);
    top_bits = gcl_pkg::bit_length(64'(top));
    sum_e    = (SUM_W'(top_bits) << 1) - SUM_W'(1) + SUM_W'(order);
    sum      = (mode == gcl_pkg::MODE_EXPGOLOMB) ? sum_e : sum_g;
    if (sum > SUM_W'(gcl_pkg::LEN_MAX)) begin
      len_nxt = gcl_pkg::LEN_MAX;
    end else begin
      len_nxt = sum[gcl_pkg::LEN_W-1:0];
    end
  end

  assign up_ready        = !valid_r || !out_stall;
  assign out_valid       = valid_r;
  assign out_code_length = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_valid && up_ready) begin
      len_r <= len_nxt;
    end
  end

endmodule

// ===== design/golomb_code_length.sv =====
// top level of the golomb / exp-golomb code length block: config registers, front stage,
// quotient cell chain and tail; depends on gcl_pkg, gcl_cell and gcl_tail
//
// Takes one signed value per request and returns the bit length of its Golomb code
// (divisor m) or exp-Golomb code (order k), chosen by the code_mode register. The value
// is zigzag mapped in a front register, then divided by m in a chain of VALUE_WIDTH
// cells, each producing one quotient bit and passing its partial remainder on; the tail
// adds the unary and remainder lengths (or forms the exp-Golomb length from a value
// carried alongside) and saturates to 17 bits. One request is taken every clock cycle
// unless in_stall holds it off; a result passes through the front register, the cell
// chain and the output register in turn. Every stage has its own valid and holds only
// while the stage after it is full and stalled, so gaps in the stream are squeezed out
// under output backpressure. Configuration writes must be done with the block empty; the
// values derived from the divisor are registered again from the config registers.
module golomb_code_length #(
  parameter int VALUE_WIDTH = gcl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [VALUE_WIDTH-1:0]  in_signed_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gcl_pkg::LEN_W-1:0]      out_code_length,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [gcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DW = gcl_pkg::DIV_W;
  localparam int EW = gcl_pkg::EXTRA_W;

  // configuration registers as written
  logic                        cfg_mode_r;
  logic [DW-1:0]               cfg_divisor_r;
  logic [gcl_pkg::ORDER_W-1:0] cfg_order_r;

  // values derived from the divisor, registered from the written divisor register
  logic [DW-1:0]               divisor_r, divisor_nxt;
  logic [gcl_pkg::LEN_W-1:0]   thresh_r, thresh_nxt;
  logic [EW-1:0]               extra_lo_r, extra_lo_nxt;
  logic [EW-1:0]               extra_hi_r, extra_hi_nxt;
  logic [gcl_pkg::BITLEN_W-1:0] div_bits;

  // front stage
  logic                        front_valid_r;
  logic [VALUE_WIDTH-1:0]      u_r, u_nxt;
  logic [VALUE_WIDTH:0]        top_r, top_nxt;
  logic                        front_ready;

  // stage 0 is the front register, stage VALUE_WIDTH the last cell
  logic                        st_valid [0:VALUE_WIDTH];
  logic                        st_ready [0:VALUE_WIDTH];
  logic [DW-1:0]               st_rem   [0:VALUE_WIDTH];
  logic [VALUE_WIDTH-1:0]      st_dq    [0:VALUE_WIDTH];
  logic [VALUE_WIDTH:0]        st_top   [0:VALUE_WIDTH];

  // config writes; an index past the last register is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r    <= gcl_pkg::MODE_GOLOMB;
      cfg_divisor_r <= DW'(1);
      cfg_order_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcl_pkg::CFG_CODE_MODE:       cfg_mode_r    <= cfg_wdata[0];
        gcl_pkg::CFG_GOLOMB_DIVISOR:  cfg_divisor_r <= cfg_wdata[DW-1:0];
        gcl_pkg::CFG_EXPGOLOMB_ORDER: cfg_order_r   <= cfg_wdata[gcl_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // divisor zero acts as one; remainder code length by the truncated binary rule
  always_comb begin
    divisor_nxt  = (cfg_divisor_r == '0) ? DW'(1) : cfg_divisor_r;
    div_bits     = gcl_pkg::bit_length(64'(divisor_nxt));
    thresh_nxt   = '0;
    extra_lo_nxt = '0;
    extra_hi_nxt = '0;
    if (divisor_nxt == DW'(1)) begin
      // unary only
    end else if ((divisor_nxt & (divisor_nxt - DW'(1))) == '0) begin
      extra_lo_nxt = EW'(div_bits - 1'b1);
      extra_hi_nxt = EW'(div_bits - 1'b1);
    end else begin
      extra_lo_nxt = EW'(div_bits - 1'b1);
      extra_hi_nxt = EW'(div_bits);
      thresh_nxt   = (gcl_pkg::LEN_W'(1) << div_bits) - gcl_pkg::LEN_W'(divisor_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r  <= DW'(1);
      thresh_r   <= '0;
      extra_lo_r <= '0;
      extra_hi_r <= '0;
    end else begin
      divisor_r  <= divisor_nxt;
      thresh_r   <= thresh_nxt;
      extra_lo_r <= extra_lo_nxt;
      extra_hi_r <= extra_hi_nxt;
    end
  end

  // zigzag without an adder: negative v maps to ~(2v)
  always_comb begin
    u_nxt   = {in_signed_value[VALUE_WIDTH-2:0], 1'b0} ^ {VALUE_WIDTH{in_signed_value[VALUE_WIDTH-1]}};
    // exp-golomb prefix operand (u >> k) + 1
    top_nxt = ({1'b0, u_nxt} >> cfg_order_r) + (VALUE_WIDTH + 1)'(1);
  end

  assign front_ready = !front_valid_r || st_ready[0];
  assign in_stall    = !front_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (front_ready) begin
      front_valid_r <= in_valid;
    end
    if (in_valid && front_ready) begin
      u_r   <= u_nxt;
      top_r <= top_nxt;
    end
  end

  assign st_valid[0] = front_valid_r;
  assign st_rem[0]   = '0;
  assign st_dq[0]    = u_r;
  assign st_top[0]   = top_r;

  // quotient chain, most significant bit first
  for (genvar i = 0; i < VALUE_WIDTH; i++) begin : g_cell
    gcl_cell #(
      .VW (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (st_valid[i]),
      .up_ready   (st_ready[i]),
      .down_valid (st_valid[i+1]),
      .down_ready (st_ready[i+1]),
      .divisor    (divisor_r),
      .in_rem     (st_rem[i]),
      .in_dq      (st_dq[i]),
      .in_top     (st_top[i]),
      .out_rem    (st_rem[i+1]),
      .out_dq     (st_dq[i+1]),
      .out_top    (st_top[i+1])
    );
  end

  gcl_tail #(
    .VW (VALUE_WIDTH)
  ) u_tail (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (st_valid[VALUE_WIDTH]),
    .up_ready        (st_ready[VALUE_WIDTH]),
    .quo             (st_dq[VALUE_WIDTH]),
    .rem             (st_rem[VALUE_WIDTH]),
    .top             (st_top[VALUE_WIDTH]),
    .mode            (cfg_mode_r),
    .order           (cfg_order_r),
    .thresh          (thresh_r),
    .extra_lo        (extra_lo_r),
    .extra_hi        (extra_hi_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_length (out_code_length)
  );

`ifndef SYNTHESIS
  // an accepted request always lands in the front register
  a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> front_valid_r)
    else $error("accepted request not captured by front stage");

  // the last cell holds its item while the tail cannot take it
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_valid[VALUE_WIDTH] && !st_ready[VALUE_WIDTH]) |=> st_valid[VALUE_WIDTH])
    else $error("item dropped at the end of the cell chain");

  // remainder code lengths differ by at most one bit
  a_extra_span: assert property (@(posedge clk) disable iff (!rst_n)
    (extra_hi_r >= extra_lo_r) && (extra_hi_r - extra_lo_r <= EW'(1)))
    else $error("inconsistent remainder length table");

  // every code has at least one bit
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_code_length != '0))
    else $error("zero code length delivered");
`endif

endmodule
